FILE: sv/pple_pkg.sv
// ============================================================================
// pple_pkg
// Shared types and constants for the ping-pong lease exchange.
// ============================================================================
`default_nettype none

package pple_pkg;

  localparam int READER_COUNT_WIDTH = 8;
  localparam int GEN_WIDTH          = 32;
  localparam int PAYLOAD_WIDTH      = 32;
  localparam int STEP_WIDTH         = 64;
  localparam int CAMGEN_WIDTH       = 64;
  localparam int CFG_DATA_WIDTH     = 64;
  localparam int CFG_IDX_WIDTH      = 2;

  localparam logic [READER_COUNT_WIDTH-1:0] READER_MAX = '1;
  localparam logic [GEN_WIDTH-1:0]          GEN_MAX    = '1;
  localparam logic [GEN_WIDTH-1:0]          GEN_ONE    = GEN_WIDTH'(1);

  typedef enum logic [1:0] {
    CMD_PUBLISH = 2'd0,
    CMD_ACQUIRE = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_CLOSE   = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_PUBLISHED     = 4'd0,
    ST_STEP_STALE    = 4'd1,
    ST_CAMGEN_STALE  = 4'd2,
    ST_EXHAUSTED     = 4'd3,
    ST_BUSY          = 4'd4,
    ST_ACQUIRED      = 4'd5,
    ST_REFUSED       = 4'd6,
    ST_RELEASED      = 4'd7,
    ST_RELEASE_ERR   = 4'd8,
    ST_CLOSED        = 4'd9,
    ST_PUB_CLOSED    = 4'd10
  } status_e;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_INIT_STEP    = 2'd0,
    CFG_INIT_CAMGEN  = 2'd1,
    CFG_INIT_PAYLOAD = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    cmd_e                     command;
    logic [STEP_WIDTH-1:0]    sim_step;
    logic [CAMGEN_WIDTH-1:0]  camera_gen;
    logic [PAYLOAD_WIDTH-1:0] payload;
    logic                     lease_slot;
  } cmd_t;

  typedef struct packed {
    status_e                       status;
    logic                          out_slot;
    logic [GEN_WIDTH-1:0]          out_exchange_gen;
    logic [STEP_WIDTH-1:0]         out_sim_step;
    logic [CAMGEN_WIDTH-1:0]       out_camera_gen;
    logic [PAYLOAD_WIDTH-1:0]      out_payload;
    logic [READER_COUNT_WIDTH-1:0] out_readers;
  } res_t;

  typedef struct packed {
    logic                      we;
    cfg_idx_e                  idx;
    logic [CFG_DATA_WIDTH-1:0] wdata;
  } cfg_t;

endpackage

`default_nettype wire

FILE: sv/pple_if.sv
// ============================================================================
// pple_cmd_if / pple_res_if
// Valid/ready channels for command words and result words.
// ============================================================================
`default_nettype none

interface pple_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [63:0] sim_step;
  logic [63:0] camera_gen;
  logic [31:0] payload;
  logic        lease_slot;

  modport source (output valid, command, sim_step, camera_gen, payload, lease_slot,
                  input ready);
  modport sink   (input valid, command, sim_step, camera_gen, payload, lease_slot,
                  output ready);
endinterface

interface pple_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic        out_slot;
  logic [31:0] out_exchange_gen;
  logic [63:0] out_sim_step;
  logic [63:0] out_camera_gen;
  logic [31:0] out_payload;
  logic [7:0]  out_readers;

  modport source (output valid, status, out_slot, out_exchange_gen, out_sim_step,
                  out_camera_gen, out_payload, out_readers,
                  input ready);
  modport sink   (input valid, status, out_slot, out_exchange_gen, out_sim_step,
                  out_camera_gen, out_payload, out_readers,
                  output ready);
endinterface

`default_nettype wire

FILE: sv/pple_core.sv
// ============================================================================
// pple_core
// Exchange state (two slots, generations, reader counts) and the
// combinational command evaluation.
// ============================================================================
`default_nettype none

module pple_core
  import pple_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire logic exec_i,
  input  wire cmd_t cmd_i,
  output res_t      res_o
);

  logic [STEP_WIDTH-1:0]         init_step_q;
  logic [CAMGEN_WIDTH-1:0]       init_camgen_q;
  logic [STEP_WIDTH-1:0]         step_q    [2];
  logic [CAMGEN_WIDTH-1:0]       camgen_q  [2];
  logic [PAYLOAD_WIDTH-1:0]      data_q    [2];
  logic [GEN_WIDTH-1:0]          sgen_q    [2];
  logic [READER_COUNT_WIDTH-1:0] readers_q [2];
  logic [STEP_WIDTH-1:0]         last_step_q;
  logic [CAMGEN_WIDTH-1:0]       last_camgen_q;
  logic [GEN_WIDTH-1:0]          xgen_q;
  logic                          closed_q;

  logic                          tgt, frt;
  logic [READER_COUNT_WIDTH-1:0] rd_tgt, rd_frt, rd_rel;
  logic                          pub_ok, acq_ok, rel_ok, close_go;
  logic [GEN_WIDTH-1:0]          gen_nxt;
  logic                          reinit;

  assign tgt     = xgen_q[0];
  assign frt     = ~xgen_q[0];
  assign rd_tgt  = tgt ? readers_q[1] : readers_q[0];
  assign rd_frt  = frt ? readers_q[1] : readers_q[0];
  assign rd_rel  = cmd_i.lease_slot ? readers_q[1] : readers_q[0];
  assign gen_nxt = xgen_q + GEN_ONE;
  assign reinit  = cfg_i.we && (cfg_i.idx == CFG_INIT_PAYLOAD);

  always_comb begin
    res_o    = '0;
    pub_ok   = 1'b0;
    acq_ok   = 1'b0;
    rel_ok   = 1'b0;
    close_go = 1'b0;
    unique case (cmd_i.command)
      CMD_PUBLISH: begin
        res_o.out_slot    = tgt;
        res_o.out_readers = rd_tgt;
        priority if (closed_q) begin
          res_o.status = ST_PUB_CLOSED;
        end else if (cmd_i.sim_step <= last_step_q) begin
          res_o.status = ST_STEP_STALE;
        end else if (cmd_i.camera_gen <= last_camgen_q) begin
          res_o.status = ST_CAMGEN_STALE;
        end else if (xgen_q == GEN_MAX) begin
          res_o.status = ST_EXHAUSTED;
        end else if (rd_tgt != '0) begin
          res_o.status = ST_BUSY;
        end else begin
          res_o.status           = ST_PUBLISHED;
          res_o.out_exchange_gen = gen_nxt;
          pub_ok                 = 1'b1;
        end
      end
      CMD_ACQUIRE: begin
        res_o.out_slot    = frt;
        res_o.out_readers = rd_frt;
        if (closed_q || rd_frt == READER_MAX) begin
          res_o.status = ST_REFUSED;
        end else begin
          res_o.status           = ST_ACQUIRED;
          res_o.out_readers      = rd_frt + 1'b1;
          res_o.out_exchange_gen = frt ? sgen_q[1] : sgen_q[0];
          res_o.out_sim_step     = frt ? step_q[1] : step_q[0];
          res_o.out_camera_gen   = frt ? camgen_q[1] : camgen_q[0];
          res_o.out_payload      = frt ? data_q[1] : data_q[0];
          acq_ok                 = 1'b1;
        end
      end
      CMD_RELEASE: begin
        res_o.out_slot = cmd_i.lease_slot;
        if (rd_rel == '0) begin
          res_o.status = ST_RELEASE_ERR;
        end else begin
          res_o.status      = ST_RELEASED;
          res_o.out_readers = rd_rel - 1'b1;
          rel_ok            = 1'b1;
        end
      end
      CMD_CLOSE: begin
        res_o.status = ST_CLOSED;
        close_go     = 1'b1;
      end
      default: res_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_step_q   <= '0;
      init_camgen_q <= '0;
    end else if (cfg_i.we) begin
      if (cfg_i.idx == CFG_INIT_STEP) begin
        init_step_q <= cfg_i.wdata;
      end
      if (cfg_i.idx == CFG_INIT_CAMGEN) begin
        init_camgen_q <= cfg_i.wdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q        <= '{default: '0};
      camgen_q      <= '{default: '0};
      data_q        <= '{default: '0};
      sgen_q[0]     <= GEN_ONE;
      sgen_q[1]     <= '0;
      readers_q     <= '{default: '0};
      last_step_q   <= '0;
      last_camgen_q <= '0;
      xgen_q        <= GEN_ONE;
      closed_q      <= 1'b0;
    end else if (reinit) begin
      step_q[0]     <= init_step_q;
      step_q[1]     <= '0;
      camgen_q[0]   <= init_camgen_q;
      camgen_q[1]   <= '0;
      data_q[0]     <= cfg_i.wdata[PAYLOAD_WIDTH-1:0];
      data_q[1]     <= '0;
      sgen_q[0]     <= GEN_ONE;
      sgen_q[1]     <= '0;
      readers_q     <= '{default: '0};
      last_step_q   <= init_step_q;
      last_camgen_q <= init_camgen_q;
      xgen_q        <= GEN_ONE;
      closed_q      <= 1'b0;
    end else if (exec_i) begin
      if (pub_ok) begin
        step_q[tgt]   <= cmd_i.sim_step;
        camgen_q[tgt] <= cmd_i.camera_gen;
        data_q[tgt]   <= cmd_i.payload;
        sgen_q[tgt]   <= gen_nxt;
        last_step_q   <= cmd_i.sim_step;
        last_camgen_q <= cmd_i.camera_gen;
        xgen_q        <= gen_nxt;
      end
      if (acq_ok) begin
        readers_q[frt] <= res_o.out_readers;
      end
      if (rel_ok) begin
        readers_q[cmd_i.lease_slot] <= res_o.out_readers;
      end
      if (close_go) begin
        closed_q <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/ping_pong_lease_exchange.sv
// ============================================================================
// ping_pong_lease_exchange
// Two-slot ping-pong packet exchange with per-slot reader leases.
// ============================================================================
// Usage:
//   cmd_i  : command words (publish, acquire, release, close), valid/ready.
//   res_o  : exactly one result word per command, in command order.
//   cfg_*  : register writes; only while no command is in flight. Writing
//            the initial payload register reloads the whole exchange.
// Pipeline: an accepted command passes the input register, then the result
//   register; the command executes against the exchange state on its way
//   into the result register.
// Throughput: one command per cycle; both stages advance together while
//   the result side takes words.
// Stall: when res_o.ready is low the result register holds; the input
//   register still takes one more command, then cmd_i.ready drops.
// Reset: asynchronous, active low. Clears the exchange state; slot zero
//   holds generation one, the exchange is open and no word is pending.
// ============================================================================
`default_nettype none

module ping_pong_lease_exchange
  import pple_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  pple_cmd_if.sink                       cmd_i,
  pple_res_if.source                     res_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [CFG_IDX_WIDTH-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_WIDTH-1:0] cfg_wdata_i
);

  logic s1_valid_q;
  cmd_t s1_cmd_q;
  logic out_valid_q;
  res_t out_res_q;
  res_t core_res;
  cfg_t cfg;
  logic adv;
  logic take;

  assign cfg.we    = cfg_we_i;
  assign cfg.idx   = cfg_idx_e'(cfg_idx_i);
  assign cfg.wdata = cfg_wdata_i;

  assign adv         = s1_valid_q && (!out_valid_q || res_o.ready);
  assign cmd_i.ready = !s1_valid_q || adv;
  assign take        = cmd_i.valid && cmd_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (take) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_cmd_q.command    <= cmd_e'(cmd_i.command);
      s1_cmd_q.sim_step   <= cmd_i.sim_step;
      s1_cmd_q.camera_gen <= cmd_i.camera_gen;
      s1_cmd_q.payload    <= cmd_i.payload;
      s1_cmd_q.lease_slot <= cmd_i.lease_slot;
    end
  end

  pple_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .exec_i (adv),
    .cmd_i  (s1_cmd_q),
    .res_o  (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_res_q <= core_res;
    end
  end

  assign res_o.valid            = out_valid_q;
  assign res_o.status           = out_res_q.status;
  assign res_o.out_slot         = out_res_q.out_slot;
  assign res_o.out_exchange_gen = out_res_q.out_exchange_gen;
  assign res_o.out_sim_step     = out_res_q.out_sim_step;
  assign res_o.out_camera_gen   = out_res_q.out_camera_gen;
  assign res_o.out_payload      = out_res_q.out_payload;
  assign res_o.out_readers      = out_res_q.out_readers;

endmodule

`default_nettype wire

FILE: sv/pple_checker.sv
// ============================================================================
// pple_checker
// Port-level checks on the result channel of the lease exchange.
// ============================================================================
`default_nettype none

module pple_checker
  import pple_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        res_valid_i,
  input wire logic        res_ready_i,
  input wire logic [3:0]  status_i,
  input wire logic        out_slot_i,
  input wire logic [63:0] out_sim_step_i,
  input wire logic [63:0] out_camera_gen_i,
  input wire logic [31:0] out_payload_i,
  input wire logic [7:0]  out_readers_i
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result word dropped while stalled");

  a_zero_contents: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && status_i != ST_ACQUIRED |->
      out_sim_step_i == '0 && out_camera_gen_i == '0 && out_payload_i == '0)
    else $error("slot contents shown on a non-acquire result");

  a_rel_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && status_i == ST_RELEASE_ERR |-> out_readers_i == '0)
    else $error("release error with nonzero reader count");

  a_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && status_i == ST_CLOSED |-> !out_slot_i && out_readers_i == '0)
    else $error("close result carries slot or readers");

endmodule

bind ping_pong_lease_exchange pple_checker u_pple_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .status_i         (res_o.status),
  .out_slot_i       (res_o.out_slot),
  .out_sim_step_i   (res_o.out_sim_step),
  .out_camera_gen_i (res_o.out_camera_gen),
  .out_payload_i    (res_o.out_payload),
  .out_readers_i    (res_o.out_readers)
);

`default_nettype wire

FILE: test/ping_pong_lease_exchange_test.sv
// ============================================================================
// ping_pong_lease_exchange_test
// Self-checking bench for the two-slot lease exchange. A ledger class keeps
// its own copy of the slots, leases and preload registers, works out the
// result word owed for every accepted command and checks the result words in
// order. A short directed sequence is followed by phases of random command
// streams under different preload settings, random gaps on both channels and
// one long result-side hold.
// ============================================================================
`default_nettype none

module ping_pong_lease_exchange_test
  import pple_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT       = 200000;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned MAX_PRINTS  = 50;
  localparam logic [63:0] ALL_ONES    = '1;

  class lease_ledger;
    logic [STEP_WIDTH-1:0]         init_step;
    logic [CAMGEN_WIDTH-1:0]       init_camgen;
    logic [PAYLOAD_WIDTH-1:0]      init_payload;
    logic [STEP_WIDTH-1:0]         slot_step [2];
    logic [CAMGEN_WIDTH-1:0]       slot_camgen [2];
    logic [PAYLOAD_WIDTH-1:0]      slot_data [2];
    logic [GEN_WIDTH-1:0]          slot_gen [2];
    logic [READER_COUNT_WIDTH-1:0] slot_readers [2];
    logic [STEP_WIDTH-1:0]         last_step;
    logic [CAMGEN_WIDTH-1:0]       last_camgen;
    logic [GEN_WIDTH-1:0]          exchange_gen;
    bit                            closed;
    res_t                          answers_due [$];
    int unsigned                   mismatches;

    function new();
      init_step    = '0;
      init_camgen  = '0;
      init_payload = '0;
      mismatches   = 0;
      reload();
    endfunction

    function void reload();
      slot_step[0]    = init_step;
      slot_camgen[0]  = init_camgen;
      slot_data[0]    = init_payload;
      slot_gen[0]     = GEN_ONE;
      slot_step[1]    = '0;
      slot_camgen[1]  = '0;
      slot_data[1]    = '0;
      slot_gen[1]     = '0;
      slot_readers[0] = '0;
      slot_readers[1] = '0;
      last_step       = init_step;
      last_camgen     = init_camgen;
      exchange_gen    = GEN_ONE;
      closed          = 1'b0;
    endfunction

    function void write_register(cfg_idx_e idx, logic [CFG_DATA_WIDTH-1:0] value);
      case (idx)
        CFG_INIT_STEP: begin
          init_step = value;
        end
        CFG_INIT_CAMGEN: begin
          init_camgen = value;
        end
        CFG_INIT_PAYLOAD: begin
          init_payload = value[PAYLOAD_WIDTH-1:0];
          reload();
        end
        default: begin
        end
      endcase
    endfunction

    function res_t run_command(cmd_t c);
      res_t r;
      logic t;
      logic f;
      r = '0;
      t = exchange_gen[0];
      f = ~exchange_gen[0];
      case (c.command)
        CMD_PUBLISH: begin
          r.out_slot    = t;
          r.out_readers = slot_readers[t];
          if (closed) begin
            r.status = ST_PUB_CLOSED;
          end else if (c.sim_step <= last_step) begin
            r.status = ST_STEP_STALE;
          end else if (c.camera_gen <= last_camgen) begin
            r.status = ST_CAMGEN_STALE;
          end else if (exchange_gen == GEN_MAX) begin
            r.status = ST_EXHAUSTED;
          end else if (slot_readers[t] != '0) begin
            r.status = ST_BUSY;
          end else begin
            exchange_gen       = exchange_gen + GEN_ONE;
            slot_step[t]       = c.sim_step;
            slot_camgen[t]     = c.camera_gen;
            slot_data[t]       = c.payload;
            slot_gen[t]        = exchange_gen;
            last_step          = c.sim_step;
            last_camgen        = c.camera_gen;
            r.status           = ST_PUBLISHED;
            r.out_exchange_gen = exchange_gen;
          end
        end
        CMD_ACQUIRE: begin
          r.out_slot = f;
          if (closed || slot_readers[f] == READER_MAX) begin
            r.status = ST_REFUSED;
          end else begin
            slot_readers[f]    = slot_readers[f] + 1'b1;
            r.status           = ST_ACQUIRED;
            r.out_exchange_gen = slot_gen[f];
            r.out_sim_step     = slot_step[f];
            r.out_camera_gen   = slot_camgen[f];
            r.out_payload      = slot_data[f];
          end
          r.out_readers = slot_readers[f];
        end
        CMD_RELEASE: begin
          r.out_slot = c.lease_slot;
          if (slot_readers[c.lease_slot] == '0) begin
            r.status = ST_RELEASE_ERR;
          end else begin
            slot_readers[c.lease_slot] = slot_readers[c.lease_slot] - 1'b1;
            r.status      = ST_RELEASED;
            r.out_readers = slot_readers[c.lease_slot];
          end
        end
        default: begin
          closed   = 1'b1;
          r.status = ST_CLOSED;
        end
      endcase
      return r;
    endfunction

    function void take_command(cmd_t c);
      answers_due.push_back(run_command(c));
    endfunction

    task flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      if (mismatches <= MAX_PRINTS) begin
        $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
      end
    endtask

    task match_answer(res_t got);
      res_t want;
      if (answers_due.size() == 0) begin
        flag_mismatch("unrequested word status", got.status, '0);
      end else begin
        want = answers_due.pop_front();
        if (got.status !== want.status)
          flag_mismatch("status", got.status, want.status);
        if (got.out_slot !== want.out_slot)
          flag_mismatch("out_slot", got.out_slot, want.out_slot);
        if (got.out_exchange_gen !== want.out_exchange_gen)
          flag_mismatch("out_exchange_gen", got.out_exchange_gen, want.out_exchange_gen);
        if (got.out_sim_step !== want.out_sim_step)
          flag_mismatch("out_sim_step", got.out_sim_step, want.out_sim_step);
        if (got.out_camera_gen !== want.out_camera_gen)
          flag_mismatch("out_camera_gen", got.out_camera_gen, want.out_camera_gen);
        if (got.out_payload !== want.out_payload)
          flag_mismatch("out_payload", got.out_payload, want.out_payload);
        if (got.out_readers !== want.out_readers)
          flag_mismatch("out_readers", got.out_readers, want.out_readers);
      end
    endtask
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic                      cfg_we;
  logic [CFG_IDX_WIDTH-1:0]  cfg_idx;
  logic [CFG_DATA_WIDTH-1:0] cfg_wdata;

  bit          sender_gaps;
  bit          receiver_gaps;
  bit          hold_results;
  int unsigned cycles;
  lease_ledger lg;

  pple_cmd_if cmd_ch ();
  pple_res_if res_ch ();

  ping_pong_lease_exchange u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cmd_i       (cmd_ch),
    .res_o       (res_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic cmd_t word_of(cmd_e op, logic [63:0] step, logic [63:0] cam,
                                   logic [31:0] pay, logic ls);
    cmd_t c;
    c.command    = op;
    c.sim_step   = step;
    c.camera_gen = cam;
    c.payload    = pay;
    c.lease_slot = ls;
    return c;
  endfunction

  // Mostly well-formed traffic built on the ledger's current state, with
  // some stale publishes, stray releases and random non-close words mixed in.
  function automatic cmd_t next_command(bit acquire_heavy);
    cmd_t        c;
    int unsigned roll;
    logic [63:0] bump;
    c = word_of(cmd_e'($urandom_range(0, 2)), {$urandom, $urandom}, {$urandom, $urandom},
                $urandom, 1'($urandom_range(0, 1)));
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      return c;
    end
    roll = $urandom_range(0, 99);
    if (acquire_heavy) begin
      c.command = (roll < 5) ? CMD_PUBLISH : (roll < 90) ? CMD_ACQUIRE : CMD_RELEASE;
    end else begin
      c.command = (roll < 40) ? CMD_PUBLISH : (roll < 70) ? CMD_ACQUIRE : CMD_RELEASE;
    end
    if (c.command == CMD_PUBLISH) begin
      bump = ($urandom_range(0, 9) == 0) ? {32'd0, $urandom} : 64'($urandom_range(1, 1000));
      if ($urandom_range(0, 9) == 0)
        c.sim_step = lg.last_step - 64'($urandom_range(0, 50));
      else
        c.sim_step = lg.last_step + bump;
      bump = ($urandom_range(0, 9) == 0) ? {32'd0, $urandom} : 64'($urandom_range(1, 1000));
      if ($urandom_range(0, 9) == 0)
        c.camera_gen = lg.last_camgen - 64'($urandom_range(0, 50));
      else
        c.camera_gen = lg.last_camgen + bump;
    end else if (c.command == CMD_RELEASE && $urandom_range(0, 9) != 0) begin
      if (lg.slot_readers[0] != '0 && lg.slot_readers[1] == '0)
        c.lease_slot = 1'b0;
      else if (lg.slot_readers[1] != '0 && lg.slot_readers[0] == '0)
        c.lease_slot = 1'b1;
    end
    return c;
  endfunction

  task automatic send_command(cmd_t c);
    int unsigned gap;
    gap = sender_gaps ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.command    <= c.command;
    cmd_ch.sim_step   <= c.sim_step;
    cmd_ch.camera_gen <= c.camera_gen;
    cmd_ch.payload    <= c.payload;
    cmd_ch.lease_slot <= c.lease_slot;
    @(posedge clk);
    while (!(cmd_ch.valid && cmd_ch.ready)) @(posedge clk);
    lg.take_command(c);
  endtask

  task automatic drain();
    cmd_ch.valid <= 1'b0;
    while (lg.answers_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_register(cfg_idx_e idx, logic [CFG_DATA_WIDTH-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    lg.write_register(idx, value);
  endtask

  task automatic configure(logic [63:0] step, logic [63:0] cam, logic [31:0] pay,
                           bit reload);
    put_register(CFG_INIT_STEP, step);
    put_register(CFG_INIT_CAMGEN, cam);
    if (reload) put_register(CFG_INIT_PAYLOAD, {32'd0, pay});
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(int n, bit acquire_heavy, bit with_close);
    int close_at;
    close_at = with_close ? n - int'($urandom_range(5, 20)) : -1;
    for (int i = 0; i < n; i++) begin
      if (i == close_at)
        send_command(word_of(CMD_CLOSE, {$urandom, $urandom}, {$urandom, $urandom},
                             $urandom, 1'($urandom_range(0, 1))));
      else
        send_command(next_command(acquire_heavy));
    end
    drain();
  endtask

  // result side: random ready gaps, plus one long hold when asked
  initial begin
    res_t got;
    res_ch.ready <= 1'b0;
    wait (rst_n);
    forever begin
      int unsigned gap;
      if (hold_results) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end
      gap = receiver_gaps ? $urandom_range(0, 9) : 0;
      if (gap != 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(res_ch.valid && res_ch.ready)) @(posedge clk);
      got.status           = status_e'(res_ch.status);
      got.out_slot         = res_ch.out_slot;
      got.out_exchange_gen = res_ch.out_exchange_gen;
      got.out_sim_step     = res_ch.out_sim_step;
      got.out_camera_gen   = res_ch.out_camera_gen;
      got.out_payload      = res_ch.out_payload;
      got.out_readers      = res_ch.out_readers;
      lg.match_answer(got);
    end
  end

  initial begin
    lg = new();
    cycles            <= 0;
    sender_gaps       = 1'b1;
    receiver_gaps     = 1'b1;
    hold_results      = 1'b0;
    cmd_ch.valid      <= 1'b0;
    cmd_ch.command    <= CMD_PUBLISH;
    cmd_ch.sim_step   <= '0;
    cmd_ch.camera_gen <= '0;
    cmd_ch.payload    <= '0;
    cmd_ch.lease_slot <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= CFG_INIT_STEP;
    cfg_wdata         <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: preload is all zero, slot 0 is front at generation 1
    // (exhausted needs 2^32 - 2 publishes and is out of reach here)
    send_command(word_of(CMD_ACQUIRE, '0, '0, '0, 1'b0));
    send_command(word_of(CMD_PUBLISH, 64'd0, 64'd5, 32'd1, 1'b0));
    send_command(word_of(CMD_PUBLISH, 64'd7, 64'd0, 32'd1, 1'b0));
    send_command(word_of(CMD_PUBLISH, 64'd7, 64'd5, 32'hFFFF_FFFF, 1'b1));
    send_command(word_of(CMD_PUBLISH, 64'd8, 64'd6, 32'd2, 1'b0));
    send_command(word_of(CMD_ACQUIRE, '0, '0, '0, 1'b0));
    send_command(word_of(CMD_RELEASE, '0, '0, '0, 1'b0));
    send_command(word_of(CMD_RELEASE, '0, '0, '0, 1'b0));
    send_command(word_of(CMD_PUBLISH, ALL_ONES, ALL_ONES, 32'd0, 1'b0));
    send_command(word_of(CMD_PUBLISH, ALL_ONES, ALL_ONES, 32'd3, 1'b1));
    send_command(word_of(CMD_ACQUIRE, '0, '0, '0, 1'b1));
    send_command(word_of(CMD_RELEASE, '0, '0, '0, 1'b1));
    send_command(word_of(CMD_RELEASE, '0, '0, '0, 1'b1));
    send_command(word_of(CMD_CLOSE, '0, '0, '0, 1'b0));
    send_command(word_of(CMD_CLOSE, '0, '0, '0, 1'b1));
    send_command(word_of(CMD_PUBLISH, 64'd1, 64'd1, 32'd4, 1'b0));
    send_command(word_of(CMD_ACQUIRE, '0, '0, '0, 1'b0));
    send_command(word_of(CMD_RELEASE, '0, '0, '0, 1'b0));
    send_command(word_of(CMD_RELEASE, '0, '0, '0, 1'b0));
    send_command(word_of(CMD_RELEASE, '0, '0, '0, 1'b1));
    drain();

    for (int p = 0; p < 10; p++) begin
      sender_gaps   = (p % 3 != 1);
      receiver_gaps = (p % 4 != 2);
      case (p)
        0: begin
          configure('0, '0, '0, 1'b1);
          run_phase(150, 1'b0, 1'b1);
        end
        1: begin
          configure(ALL_ONES, ALL_ONES, 32'hFFFF_FFFF, 1'b1);
          run_phase(80, 1'b0, 1'b0);
        end
        2: begin
          configure('0, ALL_ONES, $urandom, 1'b1);
          run_phase(80, 1'b0, 1'b1);
        end
        3: begin
          // lease pile-up until the front count saturates
          configure({32'd0, $urandom}, {32'd0, $urandom}, $urandom, 1'b1);
          run_phase(400, 1'b1, 1'b0);
        end
        4: begin
          // preload changes without a reload leave the exchange as it was
          configure({$urandom, $urandom}, {$urandom, $urandom}, '0, 1'b0);
          run_phase(120, 1'b0, 1'b1);
        end
        5: begin
          configure({$urandom, $urandom}, {$urandom, $urandom}, $urandom, 1'b1);
          sender_gaps  = 1'b0;
          hold_results = 1'b1;
          run_phase(150, 1'b0, 1'b0);
        end
        6: begin
          // steps run into the top of the range and wrap
          configure(ALL_ONES - 64'd300, ALL_ONES - 64'd300, $urandom, 1'b1);
          run_phase(100, 1'b0, 1'b1);
        end
        default: begin
          configure({32'd0, $urandom}, {32'd0, $urandom}, $urandom, 1'b1);
          run_phase(150, 1'b0, p[0]);
        end
      endcase
    end

    repeat (10) @(posedge clk);
    if (lg.mismatches == 0 && lg.answers_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
